>>> rtl/nbe_pkg.sv
// Shared types, constants and register codes for the neighbour bond energy block.
`timescale 1ns / 1ps

package nbe_pkg;

  // Field widths
  localparam int CELL_LABEL_BITS = 16;
  localparam int ENERGY_BITS     = 29;
  localparam int GRID_WIDTH_BITS = 11;
  localparam int GRID_HEIGHT_BITS = 16;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 2;

  // Parameter defaults
  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_LABEL_BITS = 16;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOND_MODE   = 2'd2;

  // Register reset values
  localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 11'd1024;
  localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 16'd1;
  localparam logic                        BOND_MODE_RESET   = 1'b0;

  // Bond mode codes
  localparam logic MODE_ORTHOGONAL = 1'b0;
  localparam logic MODE_DIAGONAL   = 1'b1;

  // Up to four bonds per cell
  localparam int BOND_BITS = 3;

  // Running total saturates here
  localparam logic [ENERGY_BITS-1:0] TOTAL_LIMIT = 29'd268435456;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // One classified cell: bonds it closes and whether it ends the grid
  typedef struct packed {
    logic [BOND_BITS-1:0] bonds;
    logic                 last;
  } bond_beat_t;

endpackage

>>> rtl/nbe_if.sv
// Stream interfaces for cell labels in and grid energy out.
`timescale 1ns / 1ps

interface nbe_cell_if
  import nbe_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [CELL_LABEL_BITS-1:0] cell_label;

  modport source (output valid, output cell_label, input ready);
  modport sink (input valid, input cell_label, output ready);
endinterface

interface nbe_energy_if
  import nbe_pkg::*;
  ();
  logic                          valid;
  logic                          ready;
  logic signed [ENERGY_BITS-1:0] grid_energy;

  modport source (output valid, output grid_energy, input ready);
  modport sink (input valid, input grid_energy, output ready);
endinterface

>>> rtl/nbe_front.sv
// Front end: configuration, grid position, row store and per-cell bond count.
`timescale 1ns / 1ps

module nbe_front
  import nbe_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int LABEL_BITS = DEFAULT_LABEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  nbe_cell_if.sink                  cell_in,
  output bond_beat_t                beat,
  output logic                      beat_valid,
  input  logic                      beat_ready,
  output logic                      restart
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CMP_BITS = (LABEL_BITS < CELL_LABEL_BITS) ? LABEL_BITS : CELL_LABEL_BITS;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > GRID_WIDTH_BITS) ?
                      $clog2(MAX_WIDTH + 1) : GRID_WIDTH_BITS;
  localparam logic [WW-1:0] MAX_W     = WW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

  logic [GRID_WIDTH_BITS-1:0]  grid_width;
  logic [GRID_HEIGHT_BITS-1:0] grid_height;
  logic                        bond_mode;

  logic [CMP_BITS-1:0] row_store [MAX_WIDTH];
  logic [CMP_BITS-1:0] north_label;
  logic [CMP_BITS-1:0] northeast_label;
  logic [CMP_BITS-1:0] west_label;
  logic [CMP_BITS-1:0] northwest_label;
  logic [AW-1:0]       column_count;
  logic [GRID_HEIGHT_BITS-1:0] row_count;

  logic [AW-1:0]       column_count_next;
  logic [GRID_HEIGHT_BITS-1:0] row_count_next;
  logic [AW-1:0]       north_addr;
  logic [AW-1:0]       northeast_addr;
  logic [WW-1:0]       width_ext;
  logic [AW-1:0]       last_col;
  logic [GRID_HEIGHT_BITS-1:0] last_row;
  logic                accept;
  logic [CMP_BITS-1:0] lab;
  logic                has_west;
  logic                has_north;
  logic                has_northeast;
  logic                at_row_end;
  logic                at_grid_end;
  logic                bond_w;
  logic                bond_n;
  logic                bond_nw;
  logic                bond_ne;

  // Decode register writes; a write to a known register restarts the grid
  assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT ||
                              cfg_index == REG_BOND_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
      bond_mode   <= BOND_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GRID_WIDTH_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GRID_HEIGHT_BITS-1:0];
        REG_BOND_MODE:   bond_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective grid limits: zero acts as one, width clamps to the store
  always_comb begin
    width_ext = WW'(grid_width);
    if (width_ext == '0) begin
      last_col = '0;
    end else if (width_ext > MAX_W) begin
      last_col = LAST_ADDR;
    end else begin
      last_col = AW'(width_ext - 1'b1);
    end
    last_row = (grid_height == '0) ? '0 : grid_height - 1'b1;
  end

  // Classify the incoming cell
  assign cell_in.ready = beat_ready;
  assign accept        = cell_in.valid && cell_in.ready;
  assign lab           = cell_in.cell_label[CMP_BITS-1:0];
  assign has_west      = (column_count != '0);
  assign has_north     = (row_count != '0);
  assign has_northeast = (column_count != last_col);
  assign at_row_end    = !has_northeast;
  assign at_grid_end   = at_row_end && (row_count == last_row);

  assign bond_w  = has_west && (lab == west_label);
  assign bond_n  = has_north && (lab == north_label);
  assign bond_nw = (bond_mode == MODE_DIAGONAL) && has_north && has_west &&
                   (lab == northwest_label);
  assign bond_ne = (bond_mode == MODE_DIAGONAL) && has_north && has_northeast &&
                   (lab == northeast_label);

  assign beat_valid = accept;
  assign beat.bonds = BOND_BITS'(bond_w) + BOND_BITS'(bond_n) +
                      BOND_BITS'(bond_nw) + BOND_BITS'(bond_ne);
  assign beat.last  = at_grid_end;

  // Next grid position
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (restart) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (accept) begin
      if (at_row_end) begin
        column_count_next = '0;
        row_count_next    = (row_count == last_row) ? '0 : row_count + 1'b1;
      end else begin
        column_count_next = column_count + 1'b1;
      end
    end
  end

  // Read ahead at the next column and the one after it
  assign north_addr     = column_count_next;
  assign northeast_addr = (column_count_next == LAST_ADDR) ? '0 : column_count_next + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      west_label      <= '0;
      northwest_label <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (restart || (accept && at_row_end)) begin
        west_label      <= '0;
        northwest_label <= '0;
      end else if (accept) begin
        west_label      <= lab;
        northwest_label <= north_label;
      end
    end
  end

  // Row store: one write, two registered reads with write bypass
  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[column_count] <= lab;
    end
    north_label     <= (accept && north_addr == column_count) ? lab : row_store[north_addr];
    northeast_label <= (accept && northeast_addr == column_count) ?
                       lab : row_store[northeast_addr];
  end

endmodule

>>> rtl/nbe_queue.sv
// Short queue of classified cells between front and back.
`timescale 1ns / 1ps

module nbe_queue
  import nbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       flush,
  input  logic       push,
  input  bond_beat_t push_beat,
  output logic       ready,
  input  logic       pop,
  output bond_beat_t head,
  output logic       head_valid
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bond_beat_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign ready      = (fill != CW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/nbe_back.sv
// Back end: accumulate bonds with saturation and emit the grid energy.
`timescale 1ns / 1ps

module nbe_back
  import nbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  bond_beat_t head,
  input  logic       head_valid,
  output logic       pop,
  nbe_energy_if.source energy_out
);

  logic [ENERGY_BITS-1:0] bond_total;
  logic [ENERGY_BITS-1:0] sum;
  logic [ENERGY_BITS-1:0] sum_sat;
  logic                   out_valid;
  logic [ENERGY_BITS-1:0] energy;

  // Take a beat unless it ends a grid and the result slot is still full
  assign pop = head_valid && (!head.last || !out_valid || energy_out.ready);

  assign sum     = bond_total + ENERGY_BITS'(head.bonds);
  assign sum_sat = (sum > TOTAL_LIMIT) ? TOTAL_LIMIT : sum;

  assign energy_out.valid       = out_valid;
  assign energy_out.grid_energy = $signed(energy);

  // Accumulate and hold the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      bond_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop && head.last && !restart) begin
        out_valid <= 1'b1;
      end else if (out_valid && energy_out.ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        bond_total <= '0;
      end else if (pop) begin
        if (head.last) begin
          bond_total <= '0;
        end else begin
          bond_total <= sum_sat;
        end
      end
    end
  end

  // Negate the total into the result register
  always_ff @(posedge clk) begin
    if (pop && head.last && !restart) begin
      energy <= ENERGY_BITS'(0) - sum_sat;
    end
  end

endmodule

>>> rtl/grid_like_neighbour_bond_energy_top.sv
// Top level of the neighbour bond energy block.
`timescale 1ns / 1ps

// Takes one grid cell label per clock in raster order and, after the last
// cell of a grid, returns minus the number of neighbouring cell pairs with
// equal labels (open boundaries; orthogonal bonds, plus diagonals when
// bond_mode is set). The sustained rate is one cell per clock cycle while
// the queue has room; it is set by the row store, which is read ahead at
// two columns each cycle so the north and north-east labels are ready when
// the cell arrives. The last cell's beat passes through the queue into an
// output register, where the energy waits while following cells keep
// flowing. The row store needs no clearing pass after reset. Any write to
// grid_width, grid_height or bond_mode restarts the grid; write them only
// while the block is idle.
module grid_like_neighbour_bond_energy_top
  import nbe_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int LABEL_BITS = DEFAULT_LABEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  nbe_cell_if.sink                  cell_in,
  nbe_energy_if.source              energy_out
);

  bond_beat_t front_beat;
  logic       front_valid;
  logic       queue_ready;
  bond_beat_t head;
  logic       head_valid;
  logic       pop;
  logic       restart;

  // Classify cells
  nbe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_in    (cell_in),
    .beat       (front_beat),
    .beat_valid (front_valid),
    .beat_ready (queue_ready),
    .restart    (restart)
  );

  // Decouple front and back
  nbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .flush      (restart),
    .push       (front_valid),
    .push_beat  (front_beat),
    .ready      (queue_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Accumulate and emit
  nbe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .energy_out (energy_out)
  );

endmodule

>>> bench/grid_like_neighbour_bond_energy_top_tb.sv
// Self-checking testbench for the neighbour bond energy block.
`timescale 1ns / 1ps

module grid_like_neighbour_bond_energy_top_tb;
  import nbe_pkg::*;

  localparam int MAX_W        = DEFAULT_MAX_WIDTH;
  localparam int RANDOM_CELLS = 1900;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 10;
  localparam int STALL_LIMIT  = 4000;

  // Index past the end of the register list: writes to it are dropped
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  typedef logic signed [ENERGY_BITS-1:0] energy_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  nbe_cell_if   cell_bus ();
  nbe_energy_if energy_bus ();

  grid_like_neighbour_bond_energy_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_in    (cell_bus),
    .energy_out (energy_bus)
  );

  // Label stream waiting to be sent and energies still owed by the block
  logic [CELL_LABEL_BITS-1:0] cells_to_send[$];
  energy_t                    energy_due[$];

  // Predictor copy of registers and grid position
  logic [GRID_WIDTH_BITS-1:0]  cols_reg;
  logic [GRID_HEIGHT_BITS-1:0] rows_reg;
  logic                        diag_mode;
  logic [CELL_LABEL_BITS-1:0]  above_row[MAX_W];
  logic [CELL_LABEL_BITS-1:0]  west_lab;
  logic [CELL_LABEL_BITS-1:0]  northwest_lab;
  int                          col_pos;
  int                          row_pos;
  int                          bond_count;

  // Pacing controls shared between the sequence and the two sides
  bit sender_steady;
  bit receiver_steady;
  int hold_asked;
  int hold_taken;
  int gap_left;
  int stall_left;
  bit cell_taken;

  int errors;
  int quiet_cycles;
  int sent_random;
  bit wide_done;

  logic [CELL_LABEL_BITS-1:0] palette[4];
  int                         palette_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int grid_cols();
    if (cols_reg == 0) return 1;
    if (int'(cols_reg) > MAX_W) return MAX_W;
    return int'(cols_reg);
  endfunction

  function automatic int grid_rows();
    return (rows_reg == 0) ? 1 : int'(rows_reg);
  endfunction

  task automatic restart_grid();
    west_lab      = '0;
    northwest_lab = '0;
    col_pos       = 0;
    row_pos       = 0;
    bond_count    = 0;
  endtask

  // Count the bonds one cell closes and owe an energy when the grid ends
  task automatic tally_cell(input logic [CELL_LABEL_BITS-1:0] label);
    int                         w;
    int                         h;
    int                         col;
    int                         row;
    int                         bonds;
    logic [CELL_LABEL_BITS-1:0] north;
    energy_t                    energy;
    w     = grid_cols();
    h     = grid_rows();
    col   = (col_pos >= w) ? w - 1 : col_pos;
    row   = (row_pos >= h) ? h - 1 : row_pos;
    north = (row > 0) ? above_row[col] : '0;
    bonds = 0;
    if (col > 0 && label == west_lab) bonds++;
    if (row > 0 && label == north) bonds++;
    if (diag_mode == MODE_DIAGONAL && row > 0) begin
      if (col > 0 && label == northwest_lab) bonds++;
      if (col + 1 < w && label == above_row[col + 1]) bonds++;
    end
    bond_count += bonds;
    if (bond_count > int'(TOTAL_LIMIT)) bond_count = int'(TOTAL_LIMIT);
    northwest_lab  = north;
    above_row[col] = label;
    west_lab       = label;
    if (col + 1 < w) begin
      col_pos = col + 1;
    end else begin
      col_pos       = 0;
      west_lab      = '0;
      northwest_lab = '0;
      if (row + 1 < h) begin
        row_pos = row + 1;
      end else begin
        energy = energy_t'(-bond_count);
        energy_due.push_back(energy);
        restart_grid();
      end
    end
  endtask

  // Write one register between falling edges and mirror it in the predictor
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_GRID_WIDTH: begin
        cols_reg = data[GRID_WIDTH_BITS-1:0];
        restart_grid();
      end
      REG_GRID_HEIGHT: begin
        rows_reg = data[GRID_HEIGHT_BITS-1:0];
        restart_grid();
      end
      REG_BOND_MODE: begin
        diag_mode = data[0];
        restart_grid();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cell(input logic [CELL_LABEL_BITS-1:0] label);
    cells_to_send.push_back(label);
  endtask

  // Hold until every label is sent and every energy is back, then let it settle
  task automatic wait_drained();
    while (cells_to_send.size() != 0 || cell_bus.valid || energy_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic new_palette();
    int i;
    palette_used = $urandom_range(0, 4);
    for (i = 0; i < 4; i++) palette[i] = CELL_LABEL_BITS'($urandom);
    if ($urandom_range(0, 3) == 0) palette[0] = 16'hFFFF;
    if ($urandom_range(0, 3) == 0) palette[1] = 16'h0000;
  endtask

  function automatic logic [CELL_LABEL_BITS-1:0] draw_label();
    if (palette_used == 0) return CELL_LABEL_BITS'($urandom);
    return palette[$urandom_range(0, palette_used - 1)];
  endfunction

  // One random setting followed by a few whole grids and maybe a dropped one
  task automatic run_phase(input bit wide);
    int                       w_val;
    int                       h_val;
    int                       pick;
    int                       grids;
    int                       per_grid;
    int                       g;
    int                       i;
    logic [CFG_DATA_BITS-1:0] data;
    if (wide) begin
      w_val = $urandom_range(0, 1) ? MAX_W : $urandom_range(MAX_W + 1, 2047);
      h_val = 1;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) w_val = 0;
      else if (pick < 4) w_val = $urandom_range(9, 40);
      else w_val = $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) h_val = 0;
      else h_val = (w_val > 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
    end
    data = CFG_DATA_BITS'(w_val);
    if ($urandom_range(0, 3) == 0)
      data = data | CFG_DATA_BITS'($urandom_range(0, 31) << GRID_WIDTH_BITS);
    write_reg(REG_GRID_WIDTH, data);
    write_reg(REG_GRID_HEIGHT, CFG_DATA_BITS'(h_val));
    if ($urandom_range(0, 1))
      write_reg(REG_BOND_MODE, CFG_DATA_BITS'($urandom_range(0, 65535)));
    sender_steady   = ($urandom_range(0, 3) == 0);
    receiver_steady = ($urandom_range(0, 3) == 0);
    grids    = wide ? 1 : $urandom_range(1, 4);
    per_grid = grid_cols() * grid_rows();
    for (g = 0; g < grids; g++) begin
      new_palette();
      for (i = 0; i < per_grid; i++) queue_cell(draw_label());
      sent_random += per_grid;
    end
    // Leave a grid unfinished; the next register write must drop it
    if (!wide && per_grid > 1 && $urandom_range(0, 5) == 0) begin
      new_palette();
      pick = $urandom_range(1, per_grid - 1);
      for (i = 0; i < pick; i++) queue_cell(draw_label());
      sent_random += pick;
    end
    wait_drained();
  endtask

  // Sequence: reset, directed grids, then random settings
  initial begin : sequence_run
    int i;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    cols_reg            = GRID_WIDTH_RESET;
    rows_reg            = GRID_HEIGHT_RESET;
    diag_mode           = BOND_MODE_RESET;
    for (i = 0; i < MAX_W; i++) above_row[i] = '0;
    restart_grid();
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    hold_asked      = 0;
    errors          = 0;
    sent_random     = 0;
    wide_done       = 1'b0;
    palette_used    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Short row at reset height and mode; upper width bits are dropped
    write_reg(REG_GRID_WIDTH, 16'h0803);
    queue_cell(16'hFFFF);
    queue_cell(16'hFFFF);
    queue_cell(16'h0000);
    wait_drained();

    // 2x2 in diagonal mode, all labels equal
    write_reg(REG_GRID_WIDTH, 16'd2);
    write_reg(REG_GRID_HEIGHT, 16'd2);
    write_reg(REG_BOND_MODE, {15'd0, MODE_DIAGONAL});
    repeat (4) queue_cell(16'hFFFF);
    wait_drained();

    // Same grid in orthogonal mode
    write_reg(REG_BOND_MODE, {15'd0, MODE_ORTHOGONAL});
    repeat (4) queue_cell(16'h0000);
    wait_drained();

    // Zero sizes act as single cells; hold the output so the block backs up
    write_reg(REG_GRID_WIDTH, 16'd0);
    write_reg(REG_GRID_HEIGHT, 16'd0);
    hold_asked++;
    while (hold_taken != hold_asked) @(negedge clk);
    for (i = 0; i < 8; i++) queue_cell(i[0] ? 16'hFFFF : 16'h0000);
    wait_drained();

    // Tallest grid, dropped after a few rows by a register write
    write_reg(REG_GRID_WIDTH, 16'd1);
    write_reg(REG_GRID_HEIGHT, 16'hFFFF);
    repeat (5) queue_cell(16'h5A5A);
    wait_drained();

    // Write to the spare index in mid-grid must not restart it
    write_reg(REG_GRID_WIDTH, 16'd3);
    write_reg(REG_GRID_HEIGHT, 16'd2);
    write_reg(REG_BOND_MODE, {15'd0, MODE_DIAGONAL});
    queue_cell(16'd1);
    queue_cell(16'd2);
    queue_cell(16'd1);
    wait_drained();
    write_reg(REG_SPARE, 16'hFFFF);
    queue_cell(16'd2);
    queue_cell(16'd1);
    queue_cell(16'd2);
    wait_drained();

    // Random settings; one full-width row partway through
    while (sent_random < RANDOM_CELLS) begin
      if (!wide_done && sent_random >= 300) begin
        run_phase(1'b1);
        wide_done = 1'b1;
      end else begin
        run_phase(1'b0);
      end
    end

    if (energy_due.size() != 0) begin
      $display("%0t %0d grid energies never arrived", $time, energy_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Drive label beats on the falling edge; hold a beat until it is taken
  always @(negedge clk) begin : drive_cells
    logic                       valid_next;
    logic [CELL_LABEL_BITS-1:0] label_next;
    int                         r;
    valid_next = cell_bus.valid;
    label_next = cell_bus.cell_label;
    if (rst) begin
      valid_next = 1'b0;
      label_next = '0;
      gap_left   = 0;
    end else begin
      if (cell_taken) begin
        cells_to_send.delete(0);
        valid_next = 1'b0;
        r = $urandom_range(0, 99);
        if (sender_steady || r < 60) gap_left = 0;
        else if (r < 92) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(6, 40);
      end
      if (!valid_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cells_to_send.size() != 0) begin
          valid_next = 1'b1;
          label_next = cells_to_send[0];
        end
      end
    end
    cell_bus.valid      <= valid_next;
    cell_bus.cell_label <= label_next;
  end

  // Stall the energy side at random, plus long holds on request
  always @(negedge clk) begin : drive_ready
    logic ready_next;
    if (rst) begin
      ready_next = 1'b0;
      stall_left = 0;
      hold_taken = 0;
    end else begin
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (!receiver_steady && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
      end
    end
    energy_bus.ready <= ready_next;
  end

  // Predict on each accepted label beat, check each accepted energy beat
  always @(posedge clk) begin : watch_beats
    energy_t want;
    if (rst) begin
      cell_taken <= 1'b0;
    end else begin
      cell_taken <= cell_bus.valid && cell_bus.ready;
      if (cell_bus.valid && cell_bus.ready) tally_cell(cell_bus.cell_label);
      if (energy_bus.valid && energy_bus.ready) begin
        if (energy_due.size() == 0) begin
          $display("%0t unexpected grid_energy: expected none, got %0d",
                   $time, energy_bus.grid_energy);
          errors++;
        end else begin
          want = energy_due[0];
          energy_due.delete(0);
          if (energy_bus.grid_energy !== want) begin
            $display("%0t grid_energy mismatch: expected %0d, got %0d",
                     $time, want, energy_bus.grid_energy);
            errors++;
          end
        end
      end
    end
  end

  // Give up when no beat or register write moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (cell_bus.valid && cell_bus.ready) ||
        (energy_bus.valid && energy_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout: no beat for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> files.f
rtl/nbe_pkg.sv
rtl/nbe_if.sv
rtl/nbe_front.sv
rtl/nbe_queue.sv
rtl/nbe_back.sv
rtl/grid_like_neighbour_bond_energy_top.sv
bench/grid_like_neighbour_bond_energy_top_tb.sv
